[design/vtl_pkg.sv]
// Package: shared fixed-point helpers and constants for vertex transform and light.
`default_nettype none
package vtl_pkg;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 64;
    localparam logic [CfgIdxW-1:0] REG_ROT_X = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ROT_Y = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_ROT_Z = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_SCALE = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_TRANS = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_PERSP = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_MODE = 3'd6;
    localparam logic signed [15:0] ONE_Q78 = 16'sd256;
    localparam logic signed [15:0] INV_SQRT3_Q14 = 16'sd9459;
    localparam logic [14:0] AMBIENT_Q14 = 15'd1638;
    localparam logic [14:0] UNIT_Q14 = 15'd16384;

    typedef logic signed [15:0] t_s16;

    // round half up by 2^14, then saturate; product sum fits 34 bits
    function automatic t_s16 rnd14_sat(input logic signed [33:0] v);
        logic signed [33:0] t;
        logic signed [19:0] q;
        t = v + 34'sd8192;
        q = t[33:14];
        if (q > 20'sd32767) return 16'sh7fff;
        else if (q < -20'sd32768) return 16'sh8000;
        else return q[15:0];
    endfunction

    function automatic t_s16 rnd8_sat(input logic signed [31:0] v);
        logic signed [31:0] t;
        logic signed [23:0] q;
        t = v + 32'sd128;
        q = t[31:8];
        if (q > 24'sd32767) return 16'sh7fff;
        else if (q < -24'sd32768) return 16'sh8000;
        else return q[15:0];
    endfunction

    function automatic t_s16 sat18(input logic signed [17:0] v);
        if (v > 18'sd32767) return 16'sh7fff;
        else if (v < -18'sd32768) return 16'sh8000;
        else return v[15:0];
    endfunction
endpackage
`default_nettype wire

[design/vtl_rot.sv]
// Module: one rotation stage (pair of products per output, registered).
`default_nettype none
module vtl_rot import vtl_pkg::*; #(
    parameter int unsigned Axis = 0
) (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_cs,
    input  wire t_s16        i_a0,
    input  wire t_s16        i_a1,
    input  wire t_s16        i_a2,
    output t_s16             o_a0,
    output t_s16             o_a1,
    output t_s16             o_a2
);
    t_s16 c, s, u, v;
    t_s16 n_u, n_v;
    assign c = i_cs[31:16];
    assign s = i_cs[15:0];
    // u,v are the two components moved by this axis
    always_comb begin
        case (Axis)
            0: begin u = i_a1; v = i_a2; end
            1: begin u = i_a0; v = i_a2; end
            default: begin u = i_a0; v = i_a1; end
        endcase
        n_u = rnd14_sat(34'(c * u) + 34'(s * v));
        n_v = rnd14_sat(34'(c * v) - 34'(s * u));
    end
    t_s16 r_a0, r_a1, r_a2;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (Axis)
                0: begin r_a0 <= i_a0; r_a1 <= n_u; r_a2 <= n_v; end
                1: begin r_a0 <= n_u; r_a1 <= i_a1; r_a2 <= n_v; end
                default: begin r_a0 <= n_u; r_a1 <= n_v; r_a2 <= i_a2; end
            endcase
        end
    end
    assign o_a0 = r_a0;
    assign o_a1 = r_a1;
    assign o_a2 = r_a2;
endmodule
`default_nettype wire

[design/vertex_transform_and_light.sv]
// Top level: vertex transform and lighting pipeline.
// Pipeline: input capture, three rotations, scale, translate, projection, then the output reg.
// Throughput: one vertex per clock; every stage advances when the output reg can take data.
// Stalls: the whole pipe holds while the output is full and not taken; nothing is lost.
// Reset: synchronous active-low; clears valid bits and loads register reset values.
`default_nettype none
module vertex_transform_and_light import vtl_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [CfgDataW-1:0] i_cfg_data,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, color_r, color_g, color_b
    input  wire logic [119:0]        s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // clip_x, clip_y, clip_z, clip_w, lit_r, lit_g, lit_b
    output logic [87:0]              m_axis_tdata
);
    localparam int unsigned Stages = 7;

    // configuration registers
    logic [31:0] r_rot_x, r_rot_y, r_rot_z;
    logic [47:0] r_scale, r_trans;
    logic [63:0] r_persp;
    logic        r_mode;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_x <= 32'd16384; r_rot_y <= 32'd16384; r_rot_z <= 32'd16384;
            r_scale <= '0; r_trans <= '0; r_persp <= '0; r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROT_X: r_rot_x <= i_cfg_data[31:0];
                REG_ROT_Y: r_rot_y <= i_cfg_data[31:0];
                REG_ROT_Z: r_rot_z <= i_cfg_data[31:0];
                REG_SCALE: r_scale <= i_cfg_data[47:0];
                REG_TRANS: r_trans <= i_cfg_data[47:0];
                REG_PERSP: r_persp <= i_cfg_data;
                REG_MODE:  r_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // global advance: pipe moves when the output register is free or drains
    logic en;
    logic [Stages-1:0] r_vld;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en) r_vld <= {r_vld[Stages-2:0], s_axis_tvalid};
    end

    // stage 0: input capture
    t_s16 r_p0 [3], r_n0 [3];
    logic [23:0] r_col [Stages];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_p0[k] <= s_axis_tdata[16*k +: 16];
                r_n0[k] <= s_axis_tdata[48 + 16*k +: 16];
            end
            r_col[0] <= s_axis_tdata[119:96];
            for (int k = 1; k < Stages; k++) r_col[k] <= r_col[k-1];
        end
    end

    // stages 1..3: rotations, position and normal side by side
    t_s16 px1, py1, pz1, px2, py2, pz2, px3, py3, pz3;
    t_s16 nx1, ny1, nz1, nx2, ny2, nz2, nx3, ny3, nz3;
    vtl_rot #(.Axis(0)) u_px (.i_clk, .i_en(en), .i_cs(r_rot_x),
        .i_a0(r_p0[0]), .i_a1(r_p0[1]), .i_a2(r_p0[2]), .o_a0(px1), .o_a1(py1), .o_a2(pz1));
    vtl_rot #(.Axis(1)) u_py (.i_clk, .i_en(en), .i_cs(r_rot_y),
        .i_a0(px1), .i_a1(py1), .i_a2(pz1), .o_a0(px2), .o_a1(py2), .o_a2(pz2));
    vtl_rot #(.Axis(2)) u_pz (.i_clk, .i_en(en), .i_cs(r_rot_z),
        .i_a0(px2), .i_a1(py2), .i_a2(pz2), .o_a0(px3), .o_a1(py3), .o_a2(pz3));
    vtl_rot #(.Axis(0)) u_nx (.i_clk, .i_en(en), .i_cs(r_rot_x),
        .i_a0(r_n0[0]), .i_a1(r_n0[1]), .i_a2(r_n0[2]), .o_a0(nx1), .o_a1(ny1), .o_a2(nz1));
    vtl_rot #(.Axis(1)) u_ny (.i_clk, .i_en(en), .i_cs(r_rot_y),
        .i_a0(nx1), .i_a1(ny1), .i_a2(nz1), .o_a0(nx2), .o_a1(ny2), .o_a2(nz2));
    vtl_rot #(.Axis(2)) u_nz (.i_clk, .i_en(en), .i_cs(r_rot_z),
        .i_a0(nx2), .i_a1(ny2), .i_a2(nz2), .o_a0(nx3), .o_a1(ny3), .o_a2(nz3));

    // stage 4: scale; light dot product
    t_s16 r_p4 [3];
    logic signed [31:0] r_dot;
    t_s16 p3 [3];
    assign p3[0] = px3; assign p3[1] = py3; assign p3[2] = pz3;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++)
                r_p4[k] <= rnd8_sat(32'(p3[k] * $signed(r_scale[16*k +: 16])));
            r_dot <= 32'(18'(nx3) + 18'(ny3) + 18'(nz3)) * 32'(INV_SQRT3_Q14);
        end
    end

    // stage 5: translate; light factor
    t_s16 r_p5 [3];
    logic [14:0] r_light;
    logic signed [31:0] dt;
    logic signed [17:0] dq;
    assign dt = r_dot + 32'sd8192;
    assign dq = dt[31:14];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++)
                r_p5[k] <= sat18(18'(r_p4[k]) + 18'($signed(r_trans[16*k +: 16])));
            if (dq <= 0) r_light <= AMBIENT_Q14;
            else if (dq >= 18'(UNIT_Q14 - AMBIENT_Q14)) r_light <= UNIT_Q14;
            else r_light <= 15'(dq) + AMBIENT_Q14;
        end
    end

    // stage 6: projection; color scale
    t_s16 r_c6 [4];
    logic [7:0] r_lit [3];
    logic signed [31:0] pzt;
    logic signed [24:0] pzq;
    t_s16 pz_s;
    logic [23:0] lp [3];
    // z*zf rounded, offset added before one saturation
    assign pzt = 32'(r_p5[2] * $signed(r_persp[47:32])) + 32'sd128;
    assign pzq = 25'($signed(pzt[31:8])) + 25'($signed(r_persp[63:48]));
    assign pz_s = (pzq > 25'sd32767) ? 16'sh7fff :
                  (pzq < -25'sd32768) ? 16'sh8000 : pzq[15:0];
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_mode) begin
                r_c6[0] <= rnd8_sat(32'(r_p5[0] * $signed(r_persp[15:0])));
                r_c6[1] <= rnd8_sat(32'(r_p5[1] * $signed(r_persp[31:16])));
                r_c6[2] <= pz_s;
                r_c6[3] <= sat18(-18'(r_p5[2]));
            end else begin
                r_c6[0] <= r_p5[0]; r_c6[1] <= r_p5[1]; r_c6[2] <= r_p5[2];
                r_c6[3] <= ONE_Q78;
            end
            for (int k = 0; k < 3; k++) r_lit[k] <= lp[k][21:14];
        end
    end
    always_comb begin
        for (int k = 0; k < 3; k++)
            lp[k] = 24'(r_col[5][8*k +: 8]) * 24'(r_light) + 24'd8192;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tvalid <= 1'b0;
        else if (en) m_axis_tvalid <= r_vld[Stages-1];
    end
    always_ff @(posedge i_clk) begin
        if (en) m_axis_tdata <= {r_lit[2], r_lit[1], r_lit[0],
                                 r_c6[3], r_c6[2], r_c6[1], r_c6[0]};
    end
endmodule
`default_nettype wire

[design/vtl_checker.sv]
// Checker: port-level properties of the vertex pipeline, bound to the top level.
`default_nettype none
module vtl_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [87:0]  m_axis_tdata
);
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready) else $error("input stalled with empty output");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed during stall");
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid || m_axis_tvalid |-> !$isunknown(m_axis_tvalid))
        else $error("output valid unknown");
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
endmodule
bind vertex_transform_and_light vtl_checker u_vtl_checker (.*);
`default_nettype wire
